// ----- rtl/sc2a_pkg.sv -----
package sc2a_pkg;

	// default character ring depth (one slot stays empty)
	localparam int DEF_FIFO_DEPTH = 64;

	localparam int SCAN_W = 8;
	localparam int CHAR_W = 7;

	// item kinds carried in s_tuser
	localparam logic MODE_SCAN = 1'b0;
	localparam logic MODE_READ = 1'b1;

	// scan code set 1 values
	localparam int          REL_BIT   = 7;
	localparam logic [6:0]  CODE_MASK = 7'h7F;
	localparam logic [6:0]  SC_LSHIFT = 7'h2A;
	localparam logic [6:0]  SC_RSHIFT = 7'h36;
	localparam logic [6:0]  SC_CTRL   = 7'h1D;

	// ASCII letter bounds and control-code offsets
	localparam logic [6:0] CH_LOW_A  = 7'h61;
	localparam logic [6:0] CH_LOW_Z  = 7'h7A;
	localparam logic [6:0] CH_UP_A   = 7'h41;
	localparam logic [6:0] CH_UP_Z   = 7'h5A;
	localparam logic [6:0] CTRL_LOW  = 7'h60;
	localparam logic [6:0] CTRL_UP   = 7'h40;

	// decoder to ring: one character to push
	typedef struct packed {
		logic              push;
		logic [CHAR_W-1:0] ch;
	} push_t;

	// US layout, unshifted
	function automatic logic [CHAR_W-1:0] plain_char(input logic [6:0] code);
		logic [CHAR_W-1:0] c;
		case (code)
			7'd1:  c = 7'h1B;
			7'd2:  c = 7'h31;
			7'd3:  c = 7'h32;
			7'd4:  c = 7'h33;
			7'd5:  c = 7'h34;
			7'd6:  c = 7'h35;
			7'd7:  c = 7'h36;
			7'd8:  c = 7'h37;
			7'd9:  c = 7'h38;
			7'd10: c = 7'h39;
			7'd11: c = 7'h30;
			7'd12: c = 7'h2D;
			7'd13: c = 7'h3D;
			7'd14: c = 7'h08;
			7'd15: c = 7'h09;
			7'd16: c = 7'h71;
			7'd17: c = 7'h77;
			7'd18: c = 7'h65;
			7'd19: c = 7'h72;
			7'd20: c = 7'h74;
			7'd21: c = 7'h79;
			7'd22: c = 7'h75;
			7'd23: c = 7'h69;
			7'd24: c = 7'h6F;
			7'd25: c = 7'h70;
			7'd26: c = 7'h5B;
			7'd27: c = 7'h5D;
			7'd28: c = 7'h0A;
			7'd30: c = 7'h61;
			7'd31: c = 7'h73;
			7'd32: c = 7'h64;
			7'd33: c = 7'h66;
			7'd34: c = 7'h67;
			7'd35: c = 7'h68;
			7'd36: c = 7'h6A;
			7'd37: c = 7'h6B;
			7'd38: c = 7'h6C;
			7'd39: c = 7'h3B;
			7'd40: c = 7'h27;
			7'd41: c = 7'h60;
			7'd43: c = 7'h5C;
			7'd44: c = 7'h7A;
			7'd45: c = 7'h78;
			7'd46: c = 7'h63;
			7'd47: c = 7'h76;
			7'd48: c = 7'h62;
			7'd49: c = 7'h6E;
			7'd50: c = 7'h6D;
			7'd51: c = 7'h2C;
			7'd52: c = 7'h2E;
			7'd53: c = 7'h2F;
			7'd55: c = 7'h2A;
			7'd57: c = 7'h20;
			default: c = '0;
		endcase
		return c;
	endfunction

	// US layout, shifted
	function automatic logic [CHAR_W-1:0] shift_char(input logic [6:0] code);
		logic [CHAR_W-1:0] c;
		case (code)
			7'd1:  c = 7'h1B;
			7'd2:  c = 7'h21;
			7'd3:  c = 7'h40;
			7'd4:  c = 7'h23;
			7'd5:  c = 7'h24;
			7'd6:  c = 7'h25;
			7'd7:  c = 7'h5E;
			7'd8:  c = 7'h26;
			7'd9:  c = 7'h2A;
			7'd10: c = 7'h28;
			7'd11: c = 7'h29;
			7'd12: c = 7'h5F;
			7'd13: c = 7'h2B;
			7'd14: c = 7'h08;
			7'd15: c = 7'h09;
			7'd16: c = 7'h51;
			7'd17: c = 7'h57;
			7'd18: c = 7'h45;
			7'd19: c = 7'h52;
			7'd20: c = 7'h54;
			7'd21: c = 7'h59;
			7'd22: c = 7'h55;
			7'd23: c = 7'h49;
			7'd24: c = 7'h4F;
			7'd25: c = 7'h50;
			7'd26: c = 7'h7B;
			7'd27: c = 7'h7D;
			7'd28: c = 7'h0A;
			7'd30: c = 7'h41;
			7'd31: c = 7'h53;
			7'd32: c = 7'h44;
			7'd33: c = 7'h46;
			7'd34: c = 7'h47;
			7'd35: c = 7'h48;
			7'd36: c = 7'h4A;
			7'd37: c = 7'h4B;
			7'd38: c = 7'h4C;
			7'd39: c = 7'h3A;
			7'd40: c = 7'h22;
			7'd41: c = 7'h7E;
			7'd43: c = 7'h7C;
			7'd44: c = 7'h5A;
			7'd45: c = 7'h58;
			7'd46: c = 7'h43;
			7'd47: c = 7'h56;
			7'd48: c = 7'h42;
			7'd49: c = 7'h4E;
			7'd50: c = 7'h4D;
			7'd51: c = 7'h3C;
			7'd52: c = 7'h3E;
			7'd53: c = 7'h3F;
			7'd55: c = 7'h2A;
			7'd57: c = 7'h20;
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

// ----- rtl/sc2a_ram.sv -----
module sc2a_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- rtl/sc2a_decode.sv -----
module sc2a_decode
	import sc2a_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              scan_beat,
	input  logic [SCAN_W-1:0] scan_byte,
	output push_t             push
);

	logic              shift_q;
	logic              ctrl_q;
	logic [6:0]        code;
	logic              is_rel;
	logic              is_shift;
	logic              is_ctrl;
	logic [CHAR_W-1:0] base_ch;
	logic [CHAR_W-1:0] ch;

	assign code     = scan_byte[6:0] & CODE_MASK;
	assign is_rel   = scan_byte[REL_BIT];
	assign is_shift = (code == SC_LSHIFT) || (code == SC_RSHIFT);
	assign is_ctrl  = (code == SC_CTRL);

	// modifier flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= 1'b0;
			ctrl_q  <= 1'b0;
		end else if (scan_beat) begin
			if (is_shift) begin
				shift_q <= !is_rel;
			end else if (is_ctrl) begin
				ctrl_q <= !is_rel;
			end
		end
	end

	// layout lookup, shifted entry falls back to plain, ctrl folds letters
	always_comb begin
		base_ch = shift_q ? shift_char(code) : plain_char(code);
		if (base_ch == '0) begin
			base_ch = plain_char(code);
		end
		ch = base_ch;
		if (ctrl_q) begin
			if (base_ch inside {[CH_LOW_A:CH_LOW_Z]}) begin
				ch = base_ch - CTRL_LOW;
			end else if (base_ch inside {[CH_UP_A:CH_UP_Z]}) begin
				ch = base_ch - CTRL_UP;
			end
		end
	end

	assign push.push = scan_beat && !is_rel && !is_shift && !is_ctrl && (ch != '0);
	assign push.ch   = ch;

endmodule

// ----- rtl/scancode_to_ascii_fifo.sv -----
// channel   dir  tdata                    tuser          notes
// s_axis    in   [7:0] scan_byte          [0] mode       mode 1 = read request
// m_axis    out  [6:0] character, [7] 0   [0] empty_res  one beat per read
//
// One item per cycle in, scan bytes and reads back to back, while s_tready is high.
// A read result passes the registered RAM read, then the output register.
// Reset clears the ring pointers, modifier flags and valid bits; the
// character RAM keeps no reset value.
// Output stall backs up into the read stage and then drops s_tready.
module scancode_to_ascii_fifo
	import sc2a_pkg::*;
#(
	parameter int FIFO_DEPTH = DEF_FIFO_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] scan_byte
	input  logic [0:0] s_tuser,  // [0] mode
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // [6:0] character, [7] zero
	output logic [0:0] m_tuser   // [0] empty_res
);

	localparam int ADDR_W = $clog2(FIFO_DEPTH);
	localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(FIFO_DEPTH - 1);

	logic              accept;
	logic              scan_beat;
	logic              read_beat;
	push_t             dec_push;
	logic [ADDR_W-1:0] wr_q;
	logic [ADDR_W-1:0] rd_q;
	logic [ADDR_W-1:0] wr_next;
	logic [ADDR_W-1:0] rd_next;
	logic              not_empty;
	logic              wr_en;
	logic              rd_en;
	logic [CHAR_W-1:0] ram_dout;
	logic              valid_s1;
	logic              empty_s1;
	logic              out_valid_q;
	logic [CHAR_W-1:0] out_char_q;
	logic              out_empty_q;
	logic              advance;

	// input handshake
	assign advance   = !out_valid_q || m_tready;
	assign s_tready  = !(valid_s1 && !advance);
	assign accept    = s_tvalid && s_tready;
	assign scan_beat = accept && (s_tuser[0] == MODE_SCAN);
	assign read_beat = accept && (s_tuser[0] == MODE_READ);

	sc2a_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.scan_beat (scan_beat),
		.scan_byte (s_tdata),
		.push      (dec_push)
	);

	// ring pointers; one slot stays empty to tell full from empty
	assign wr_next   = (wr_q == LAST_IDX) ? '0 : wr_q + 1'b1;
	assign rd_next   = (rd_q == LAST_IDX) ? '0 : rd_q + 1'b1;
	assign not_empty = (rd_q != wr_q);
	assign wr_en     = dec_push.push && (wr_next != rd_q);
	assign rd_en     = read_beat && not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (wr_en) begin
				wr_q <= wr_next;
			end
			if (rd_en) begin
				rd_q <= rd_next;
			end
		end
	end

	// read slot holds only committed entries, so no forwarding is needed
	sc2a_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (FIFO_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_q),
		.wr_data (dec_push.ch),
		.rd_en   (rd_en),
		.rd_addr (rd_q),
		.rd_data (ram_dout)
	);

	// read stage: waits for RAM data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= read_beat;
		end
	end

	always_ff @(posedge clk) begin
		if (read_beat) begin
			empty_s1 <= !not_empty;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_char_q  <= empty_s1 ? '0 : ram_dout;
			out_empty_q <= empty_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_char_q};
	assign m_tuser  = out_empty_q;

endmodule

// ----- rtl/sc2a_checker.sv -----
module sc2a_checker
	import sc2a_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic [0:0] s_tuser,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic [0:0] m_tuser
);

	// a stalled result beat stays up
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped while stalled");

	// an empty report carries a zero character
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == 8'h00)
		else $error("empty result with nonzero character");

	// popped characters are never zero and fit in seven bits
	a_pop_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> (m_tdata[6:0] != 7'h00) && !m_tdata[7])
		else $error("popped character out of range");

	// a fresh result follows an earlier read beat
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready && (s_tuser[0] == MODE_READ), 2))
		else $error("result without matching read beat");

endmodule

bind scancode_to_ascii_fifo sc2a_checker u_sc2a_checker (.*);
